// ===== rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and codes for the indexed list block
// Field widths, operation codes, status codes and the result record.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FN_APPEND = 3'd0;
    localparam t_func FN_INSERT = 3'd1;
    localparam t_func FN_REMOVE = 3'd2;
    localparam t_func FN_GET    = 3'd3;
    localparam t_func FN_CLEAR  = 3'd4;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_BAD  = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/ilir_if.sv =====
// ----------------------------------------------------------------------------
// ilir_if: request and response channels
// Valid/ready channels carrying one item each; an item moves when both are high.
// ----------------------------------------------------------------------------
interface ilir_req_if;
    logic                                valid;
    logic                                ready;
    ilir_pkg::t_func                     func;
    logic signed [ilir_pkg::INDEX_W-1:0] index;
    logic [ilir_pkg::VALUE_W-1:0]        value;

    modport source (output valid, func, index, value, input ready);
    modport sink   (input valid, func, index, value, output ready);
endinterface

interface ilir_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ilir_pkg::VALUE_W-1:0]  read_value;
    ilir_pkg::t_status             status;
    logic [ilir_pkg::COUNT_W-1:0]  count;

    modport source (output valid, read_value, status, count, input ready);
    modport sink   (input valid, read_value, status, count, output ready);
endinterface

// ===== rtl/ilir_mem.sv =====
// ----------------------------------------------------------------------------
// ilir_mem: entry storage
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ilir_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ilir_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilir_ctrl: operation sequencer
// Decodes one item, checks the index, and shifts entries through the memory.
// ----------------------------------------------------------------------------
module ilir_ctrl #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ilir_req_if.sink                 i_req,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output ilir_pkg::t_result        o_res,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [VALUE_BITS-1:0]    o_wr_data,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  logic [VALUE_BITS-1:0]    i_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > ilir_pkg::INDEX_W) ? CW : ilir_pkg::INDEX_W) + 2;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_INS_SHIFT = 3'd2;
    localparam logic [2:0] S_INS_PUT   = 3'd3;
    localparam logic [2:0] S_RD        = 3'd4;
    localparam logic [2:0] S_CAP       = 3'd5;
    localparam logic [2:0] S_REM_SHIFT = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0]                          r_state, n_state;
    ilir_pkg::t_func                     r_func, n_func;
    logic signed [ilir_pkg::INDEX_W-1:0] r_idx, n_idx;
    logic [VALUE_BITS-1:0]               r_word, n_word;
    logic [CW-1:0]                       r_count, n_count;
    logic [CW-1:0]                       r_pos, n_pos;
    logic [CW-1:0]                       r_ptr, n_ptr;
    logic                                r_pend, n_pend;
    logic [AW-1:0]                       r_wr_addr, n_wr_addr;
    logic [VALUE_BITS-1:0]               r_rd, n_rd;
    ilir_pkg::t_status                   r_status, n_status;

    logic signed [SW-1:0] idx_s;
    logic signed [SW-1:0] cnt_s;
    logic signed [SW-1:0] pos_s;
    logic                 ins_bad;
    logic                 pos_ok;
    logic                 full;
    logic [CW-1:0]        ptr_dec;
    logic [CW-1:0]        ptr_inc;

    assign idx_s   = SW'(r_idx);
    assign cnt_s   = SW'(r_count);
    assign pos_s   = idx_s[SW-1] ? (cnt_s + idx_s) : idx_s;
    assign ins_bad = idx_s[SW-1] || (idx_s > cnt_s);
    assign pos_ok  = !pos_s[SW-1] && (pos_s < cnt_s);
    assign full    = (r_count >= CW'(DEPTH));
    assign ptr_dec = r_ptr - 1'b1;
    assign ptr_inc = r_ptr + 1'b1;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_idx     = r_idx;
        n_word    = r_word;
        n_count   = r_count;
        n_pos     = r_pos;
        n_ptr     = r_ptr;
        n_pend    = r_pend;
        n_wr_addr = r_wr_addr;
        n_rd      = r_rd;
        n_status  = r_status;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wr_addr;
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_pos[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_idx   = i_req.index;
                    n_word  = VALUE_BITS'(i_req.value);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rd     = '0;
                n_status = ilir_pkg::ST_OK;
                n_pend   = 1'b0;
                n_state  = S_DONE;
                case (r_func)
                    ilir_pkg::FN_APPEND: begin
                        if (full) begin
                            n_status = ilir_pkg::ST_FULL;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_count[AW-1:0];
                            o_wr_data = r_word;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    ilir_pkg::FN_INSERT: begin
                        if (ins_bad) begin
                            n_status = ilir_pkg::ST_BAD;
                        end else if (full) begin
                            n_status = ilir_pkg::ST_FULL;
                        end else begin
                            n_pos   = CW'(idx_s);
                            n_ptr   = r_count;
                            n_state = S_INS_SHIFT;
                        end
                    end
                    ilir_pkg::FN_REMOVE, ilir_pkg::FN_GET: begin
                        if (!pos_ok) begin
                            n_status = ilir_pkg::ST_BAD;
                        end else begin
                            n_pos   = CW'(pos_s);
                            n_state = S_RD;
                        end
                    end
                    ilir_pkg::FN_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_status = ilir_pkg::ST_BAD;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                o_wr_en = r_pend;
                if (r_ptr > r_pos) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = ptr_dec[AW-1:0];
                    n_wr_addr = r_ptr[AW-1:0];
                    n_pend    = 1'b1;
                    n_ptr     = ptr_dec;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos[AW-1:0];
                o_wr_data = r_word;
                n_count   = r_count + 1'b1;
                n_state   = S_DONE;
            end
            S_RD: begin
                o_rd_en = 1'b1;
                n_state = S_CAP;
            end
            S_CAP: begin
                n_rd = i_rd_data;
                if (r_func == ilir_pkg::FN_REMOVE) begin
                    n_ptr   = r_pos + 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_REM_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REM_SHIFT: begin
                o_wr_en = r_pend;
                if (r_ptr < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr[AW-1:0];
                    n_wr_addr = ptr_dec[AW-1:0];
                    n_pend    = 1'b1;
                    n_ptr     = ptr_inc;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_idx     <= n_idx;
        r_word    <= n_word;
        r_pos     <= n_pos;
        r_ptr     <= n_ptr;
        r_wr_addr <= n_wr_addr;
        r_rd      <= n_rd;
        r_status  <= n_status;
    end

    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.read_value = ilir_pkg::VALUE_W'(r_rd);
    assign o_res.status     = r_status;
    assign o_res.count      = ilir_pkg::COUNT_W'(r_count);

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("shift write pending while idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("read and write hit the same entry");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_RD) |=> $stable(r_count))
        else $error("entry count changed outside an update step");

endmodule

// ===== rtl/indexed_list_insert_remove_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top: bounded ordered list of words
// Append, clear and rejected items need no shift; insert and remove move the
// entries behind the position, one memory word per cycle through one port pair.
// One item at a time; the next is accepted in the cycle after the result leaves
// the sequencer, even while it still waits in the output register.
// Reset clears the entry count and the channels; entry storage is not cleared.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_top #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ilir_req_if.sink i_req,
    ilir_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_BITS-1:0]  wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_BITS-1:0]  rd_data;
    logic                   res_valid;
    logic                   res_ready;
    ilir_pkg::t_result      res;

    logic                   r_out_valid;
    ilir_pkg::t_result      r_out;

    ilir_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ilir_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out.read_value;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.count      = r_out.count;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded indexed word list
// Drives append, insert, remove, get, clear and unknown operations through
// the request channel. A local copy of the list predicts every response, and
// each response is checked field by field in order. Items are directed
// first, then random runs that fill, drain and wander through the list.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIST_DEPTH  = 256;
    localparam int ITEM_TOTAL  = 1550;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        ilir_pkg::t_func                     fn;
        logic signed [ilir_pkg::INDEX_W-1:0] idx;
        logic [ilir_pkg::VALUE_W-1:0]        val;
    } t_list_op;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilir_req_if req_ch ();
    ilir_rsp_if rsp_ch ();

    indexed_list_insert_remove_top #(
        .DEPTH      (LIST_DEPTH),
        .VALUE_BITS (ilir_pkg::VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    t_list_op                     pending_ops[$];
    ilir_pkg::t_result            expected_results[$];
    logic [ilir_pkg::VALUE_W-1:0] list_words [LIST_DEPTH];
    int                           list_len;

    int  plan_len;
    bit  plan_grow;
    int  full_dwell;
    int  req_idle_pct;
    int  rsp_idle_pct;
    bit  rsp_hold;
    bit  req_taken;
    int  cycle_count;
    int  items_in;
    int  results_out;
    int  mismatches;
    int  op_seen [8];
    int  bad_seen;
    int  full_seen;
    int  deepest;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic ilir_pkg::t_result list_apply(t_list_op op);
        ilir_pkg::t_result r;
        int                sidx;
        int                pos;
        int                k;
        r    = '0;
        sidx = op.idx;
        pos  = (sidx < 0) ? list_len + sidx : sidx;
        case (op.fn)
            ilir_pkg::FN_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ilir_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = op.val;
                    list_len++;
                end
            end
            ilir_pkg::FN_INSERT: begin
                if (sidx < 0 || sidx > list_len) begin
                    r.status = ilir_pkg::ST_BAD;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = ilir_pkg::ST_FULL;
                end else begin
                    for (k = list_len; k > sidx; k--)
                        list_words[k] = list_words[k-1];
                    list_words[sidx] = op.val;
                    list_len++;
                end
            end
            ilir_pkg::FN_REMOVE: begin
                if (pos < 0 || pos >= list_len) begin
                    r.status = ilir_pkg::ST_BAD;
                end else begin
                    r.read_value = list_words[pos];
                    for (k = pos; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            ilir_pkg::FN_GET: begin
                if (pos < 0 || pos >= list_len)
                    r.status = ilir_pkg::ST_BAD;
                else
                    r.read_value = list_words[pos];
            end
            ilir_pkg::FN_CLEAR: list_len = 0;
            default:  r.status = ilir_pkg::ST_BAD;
        endcase
        r.count = ilir_pkg::COUNT_W'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_op(ilir_pkg::t_func fn, int idx, logic [ilir_pkg::VALUE_W-1:0] val);
        t_list_op op;
        int       sidx;
        int       pos;
        op.fn  = fn;
        op.idx = ilir_pkg::INDEX_W'(idx);
        op.val = val;
        pending_ops.push_back(op);
        sidx = op.idx;
        pos  = (sidx < 0) ? plan_len + sidx : sidx;
        case (fn)
            ilir_pkg::FN_APPEND: if (plan_len < LIST_DEPTH) plan_len++;
            ilir_pkg::FN_INSERT:
                if (sidx >= 0 && sidx <= plan_len && plan_len < LIST_DEPTH) plan_len++;
            ilir_pkg::FN_REMOVE: if (pos >= 0 && pos < plan_len) plan_len--;
            ilir_pkg::FN_CLEAR:  plan_len = 0;
            default: ;
        endcase
    endtask

    function automatic logic [ilir_pkg::VALUE_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int bad_index(int len, bit for_insert);
        case ($urandom_range(3))
            0:       return for_insert ? len + 1 : len;
            1:       return for_insert ? -1 : -len - 1;
            2:       return for_insert ? -len - 1 : len + 1;
            default: return int'($urandom_range(1023)) - 512;
        endcase
    endfunction

    task automatic queue_random(int upto);
        int              roll;
        int              p;
        ilir_pkg::t_func fn;
        while (pending_ops.size() + items_in < upto) begin
            if (plan_len == LIST_DEPTH) begin
                full_dwell++;
                if (full_dwell > 5) plan_grow = 1'b0;
            end else if (plan_len == 0) begin
                plan_grow  = 1'b1;
                full_dwell = 0;
            end else if ($urandom_range(99) < 2) begin
                plan_grow = !plan_grow;
            end
            roll = $urandom_range(99);
            if (plan_grow)
                fn = roll < 35 ? ilir_pkg::FN_APPEND : roll < 65 ? ilir_pkg::FN_INSERT :
                     roll < 75 ? ilir_pkg::FN_REMOVE : roll < 91 ? ilir_pkg::FN_GET :
                     roll < 92 ? ilir_pkg::FN_CLEAR : roll < 94 ? ilir_pkg::t_func'(5) :
                     ilir_pkg::FN_GET;
            else
                fn = roll < 10 ? ilir_pkg::FN_APPEND : roll < 20 ? ilir_pkg::FN_INSERT :
                     roll < 65 ? ilir_pkg::FN_REMOVE : roll < 92 ? ilir_pkg::FN_GET :
                     roll < 93 ? ilir_pkg::FN_CLEAR : roll < 96 ? ilir_pkg::t_func'(6) :
                     ilir_pkg::FN_GET;
            if (fn == ilir_pkg::t_func'(5) || fn == ilir_pkg::t_func'(6))
                fn = ilir_pkg::t_func'($urandom_range(7, 5));
            p = int'($urandom_range(1023)) - 512;
            if (fn == ilir_pkg::FN_INSERT) begin
                p = ($urandom_range(99) < 88) ? int'($urandom_range(plan_len)) :
                    bad_index(plan_len, 1'b1);
            end else if (fn == ilir_pkg::FN_REMOVE || fn == ilir_pkg::FN_GET) begin
                if (plan_len > 0 && $urandom_range(99) < 88) begin
                    p = $urandom_range(plan_len - 1);
                    if ($urandom_range(1)) p = p - plan_len;
                end else begin
                    p = bad_index(plan_len, 1'b0);
                end
            end
            push_op(fn, p, rand_word());
        end
    endtask

    task automatic drain_all();
        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stim
        req_ch.valid = 1'b0;
        req_ch.func  = ilir_pkg::FN_APPEND;
        req_ch.index = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        plan_len     = 0;
        plan_grow    = 1'b1;
        req_idle_pct = 9;
        rsp_idle_pct = 54;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_op(ilir_pkg::FN_GET, 0, '0);
        push_op(ilir_pkg::FN_REMOVE, -1, '0);
        push_op(ilir_pkg::FN_REMOVE, 0, '1);
        push_op(ilir_pkg::FN_CLEAR, 0, '0);
        push_op(ilir_pkg::t_func'(5), 0, '0);
        push_op(ilir_pkg::t_func'(6), 511, 32'h5555_5555);
        push_op(ilir_pkg::t_func'(7), -512, '1);
        push_op(ilir_pkg::FN_INSERT, -1, 32'h1111_1111);
        push_op(ilir_pkg::FN_INSERT, 1, 32'h2222_2222);
        push_op(ilir_pkg::FN_INSERT, 0, '1);
        push_op(ilir_pkg::FN_APPEND, 0, '0);
        push_op(ilir_pkg::FN_APPEND, -512, 32'hA5A5_A5A5);
        push_op(ilir_pkg::FN_INSERT, 3, 32'h3333_3333);
        push_op(ilir_pkg::FN_INSERT, 1, 32'h4444_4444);
        push_op(ilir_pkg::FN_GET, -5, '0);
        push_op(ilir_pkg::FN_GET, 4, '0);
        push_op(ilir_pkg::FN_GET, 5, '0);
        push_op(ilir_pkg::FN_GET, -6, '0);
        push_op(ilir_pkg::FN_REMOVE, -1, '0);
        push_op(ilir_pkg::FN_REMOVE, 0, '0);
        push_op(ilir_pkg::FN_REMOVE, 511, '0);
        push_op(ilir_pkg::FN_INSERT, -512, '0);
        push_op(ilir_pkg::FN_CLEAR, 0, '0);
        push_op(ilir_pkg::FN_GET, 0, '0);

        // fill to capacity, then knock on the full list
        while (plan_len < LIST_DEPTH) begin
            if ($urandom_range(1))
                push_op(ilir_pkg::FN_APPEND, int'($urandom_range(1023)) - 512, rand_word());
            else
                push_op(ilir_pkg::FN_INSERT, $urandom_range(plan_len), rand_word());
        end
        push_op(ilir_pkg::FN_APPEND, 0, rand_word());
        push_op(ilir_pkg::FN_INSERT, 0, rand_word());
        push_op(ilir_pkg::FN_INSERT, LIST_DEPTH, rand_word());
        push_op(ilir_pkg::FN_INSERT, LIST_DEPTH + 1, rand_word());
        push_op(ilir_pkg::FN_GET, -LIST_DEPTH, '0);
        push_op(ilir_pkg::FN_REMOVE, LIST_DEPTH - 1, '0);
        queue_random(520);
        drain_all();

        req_idle_pct = 54;
        rsp_idle_pct = 9;
        queue_random(1040);
        drain_all();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        queue_random(ITEM_TOTAL);
        drain_all();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d items: %0d append, %0d insert, %0d remove, %0d get, %0d clear",
                 items_in, op_seen[ilir_pkg::FN_APPEND], op_seen[ilir_pkg::FN_INSERT],
                 op_seen[ilir_pkg::FN_REMOVE], op_seen[ilir_pkg::FN_GET],
                 op_seen[ilir_pkg::FN_CLEAR]);
        $display("%0d other ops, %0d responses, %0d rejected, %0d full, peak fill %0d",
                 op_seen[5] + op_seen[6] + op_seen[7], results_out, bad_seen, full_seen,
                 deepest);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : rsp_backpressure
        rsp_hold = 1'b0;
        wait (items_in >= 1200);
        @(negedge i_clk);
        rsp_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        @(negedge i_clk);
        rsp_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
            if (!req_ch.valid || req_taken) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
                    req_ch.valid <= 1'b1;
                    req_ch.func  <= pending_ops[0].fn;
                    req_ch.index <= pending_ops[0].idx;
                    req_ch.value <= pending_ops[0].val;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [ilir_pkg::VALUE_W-1:0] got,
                                 logic [ilir_pkg::VALUE_W-1:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("[%0t] response %0d: %s got 0x%0h want 0x%0h",
                     $realtime, results_out, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_list_op          op;
        ilir_pkg::t_result want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        req_taken = (i_rst_n && req_ch.valid && req_ch.ready);
        if (req_taken) begin
            op.fn  = req_ch.func;
            op.idx = req_ch.index;
            op.val = req_ch.value;
            want   = list_apply(op);
            expected_results.push_back(want);
            if (pending_ops.size() != 0) pending_ops.pop_front();
            op_seen[op.fn]++;
            if (want.status == ilir_pkg::ST_BAD)  bad_seen++;
            if (want.status == ilir_pkg::ST_FULL) full_seen++;
            if (list_len > deepest) deepest = list_len;
            items_in++;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected response, count",
                              ilir_pkg::VALUE_W'(rsp_ch.count), '0);
            end else begin
                want = expected_results.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                    note_mismatch("read_value", rsp_ch.read_value, want.read_value);
                if (rsp_ch.status !== want.status)
                    note_mismatch("status", ilir_pkg::VALUE_W'(rsp_ch.status),
                                  ilir_pkg::VALUE_W'(want.status));
                if (rsp_ch.count !== want.count)
                    note_mismatch("count", ilir_pkg::VALUE_W'(rsp_ch.count),
                                  ilir_pkg::VALUE_W'(want.count));
            end
            results_out++;
        end
    end

endmodule

// ===== indexed_list_insert_remove_top.f =====
rtl/ilir_pkg.sv
rtl/ilir_if.sv
rtl/ilir_mem.sv
rtl/ilir_ctrl.sv
rtl/indexed_list_insert_remove_top.sv
test/tb.sv
